@@ hdl/ifre_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the flip/rotate engine.
`timescale 1ns / 1ps
package ifre_pkg;

  // Default geometry limits
  localparam int MAX_PIXELS_DEF = 16384;
  localparam int MAX_DIM        = 1024;

  // Field widths
  localparam int W_MODE = 3;
  localparam int W_DIM  = 11;
  localparam int W_POS  = 10;
  localparam int W_PIX  = 32;
  localparam int W_STAT = 2;
  localparam int W_CFGI = 2;
  localparam int W_TOT  = 2 * W_DIM;

  // Transform modes
  localparam logic [W_MODE-1:0] MODE_VFLIP = 3'd0;
  localparam logic [W_MODE-1:0] MODE_HFLIP = 3'd1;
  localparam logic [W_MODE-1:0] MODE_TRANS = 3'd2;
  localparam logic [W_MODE-1:0] MODE_CW    = 3'd3;
  localparam logic [W_MODE-1:0] MODE_CCW   = 3'd4;

  // Result status codes
  localparam logic [W_STAT-1:0] ST_OK     = 2'd0;
  localparam logic [W_STAT-1:0] ST_FULL   = 2'd1;
  localparam logic [W_STAT-1:0] ST_EARLY  = 2'd2;
  localparam logic [W_STAT-1:0] ST_TOOBIG = 2'd3;

  // Register indexes
  localparam logic [W_CFGI-1:0] REG_MODE   = 2'd0;
  localparam logic [W_CFGI-1:0] REG_WIDTH  = 2'd1;
  localparam logic [W_CFGI-1:0] REG_HEIGHT = 2'd2;

  // Item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic take;      // latch the incoming word
    logic eval;      // geometry, wrap and position stage
    logic addr;      // status, address, store write, counter update
    logic read;      // frame store read
    logic load_out;  // load the output register
  } ifre_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds a word that is stalled
  } ifre_sts_t;

endpackage

@@ hdl/ifre_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ifre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/ifre_ctrl.sv @@
// Sequencer for the flip/rotate engine: walks each word through eval, address, read, respond.
`timescale 1ns / 1ps
module ifre_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output ifre_pkg::ifre_cmd_t cmd,
  input  ifre_pkg::ifre_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_take_starts_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EVAL))
    else $error("accepted word did not enter eval");

  a_load_not_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("output loaded over a stalled word");

  a_read_then_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_RESP))
    else $error("read stage not followed by response");
`endif

endmodule

@@ hdl/ifre_dp.sv @@
// Datapath: registers, counters, address generation, frame store and output register.
`timescale 1ns / 1ps
module ifre_dp #(
  parameter int MAX_PIXELS = ifre_pkg::MAX_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ifre_pkg::ifre_cmd_t           cmd,
  output ifre_pkg::ifre_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [ifre_pkg::W_CFGI-1:0]   cfg_index,
  input  logic [ifre_pkg::W_DIM-1:0]    cfg_data,
  input  logic                          kind,
  input  logic [ifre_pkg::W_PIX-1:0]    pixel_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ifre_pkg::W_STAT-1:0]   status,
  output logic [ifre_pkg::W_PIX-1:0]    pixel_out,
  output logic [ifre_pkg::W_POS-1:0]    out_row,
  output logic [ifre_pkg::W_POS-1:0]    out_col,
  output logic                          last_pixel
);

  localparam int AW  = $clog2(MAX_PIXELS);
  localparam int CW  = $clog2(MAX_PIXELS + 1);
  localparam int DW  = ifre_pkg::W_DIM;
  localparam int PW  = ifre_pkg::W_POS;
  localparam int TW  = ifre_pkg::W_TOT;

  // Configuration
  logic [ifre_pkg::W_MODE-1:0] mode;
  logic [DW-1:0]               frame_width;
  logic [DW-1:0]               frame_height;

  // Frame state
  logic [CW-1:0] stored_count;
  logic [PW-1:0] read_row;
  logic [PW-1:0] read_col;

  // Per-word pipeline registers
  logic                        kind_q;
  logic [ifre_pkg::W_PIX-1:0]  pix_q;
  logic [ifre_pkg::W_MODE-1:0] m_q;
  logic [DW-1:0]               ow_q;
  logic [DW-1:0]               oh_q;
  logic [PW-1:0]               r_q;
  logic [PW-1:0]               c_q;
  logic [TW-1:0]               total_q;
  logic                        dim_bad_q;
  logic [AW-1:0]               idx_q;
  logic [ifre_pkg::W_STAT-1:0] code_q;
  logic                        last_q;

  // Eval stage logic
  logic [ifre_pkg::W_MODE-1:0] m_norm;
  logic                        swap;
  logic [DW-1:0]               ow_e;
  logic [DW-1:0]               oh_e;
  logic                        wrap;

  // Address stage logic
  logic                        geo_bad;
  logic                        full;
  logic [ifre_pkg::W_STAT-1:0] code;
  logic                        store_ok;
  logic                        fetch_ok;
  logic [DW-1:0]               ir;
  logic [DW-1:0]               ic;
  logic [TW-1:0]               idx_full;
  logic                        last;
  logic [DW-1:0]               c_inc;

  logic                        ram_we;
  logic [ifre_pkg::W_PIX-1:0]  ram_rdata;
  logic                        good_fetch_q;
  logic                        taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ifre_pkg::MODE_VFLIP;
      frame_width  <= DW'(1);
      frame_height <= DW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ifre_pkg::REG_MODE:   mode         <= cfg_data[ifre_pkg::W_MODE-1:0];
        ifre_pkg::REG_WIDTH:  frame_width  <= cfg_data;
        ifre_pkg::REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Eval: mode cleanup, output dims, read position wrap after a geometry change
  always_comb begin
    m_norm = (mode > ifre_pkg::MODE_CCW) ? ifre_pkg::MODE_VFLIP : mode;
    swap   = (m_norm >= ifre_pkg::MODE_TRANS);
    ow_e   = swap ? frame_height : frame_width;
    oh_e   = swap ? frame_width  : frame_height;
    wrap   = ({1'b0, read_row} >= oh_e) || ({1'b0, read_col} >= ow_e);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_q <= kind;
      pix_q  <= pixel_in;
    end
    if (cmd.eval) begin
      m_q       <= m_norm;
      ow_q      <= ow_e;
      oh_q      <= oh_e;
      r_q       <= wrap ? '0 : read_row;
      c_q       <= wrap ? '0 : read_col;
      total_q   <= frame_width * frame_height;
      dim_bad_q <= (frame_width == '0) || (frame_height == '0) ||
                   (frame_width > DW'(ifre_pkg::MAX_DIM)) ||
                   (frame_height > DW'(ifre_pkg::MAX_DIM));
    end
  end

  // Address: status, source coordinates and linear index
  always_comb begin
    geo_bad  = dim_bad_q || (total_q > TW'(MAX_PIXELS));
    full     = (TW'(stored_count) >= total_q);
    if (geo_bad) begin
      code = ifre_pkg::ST_TOOBIG;
    end else if (kind_q == ifre_pkg::KIND_STORE) begin
      code = full ? ifre_pkg::ST_FULL : ifre_pkg::ST_OK;
    end else begin
      code = full ? ifre_pkg::ST_OK : ifre_pkg::ST_EARLY;
    end
    store_ok = (code == ifre_pkg::ST_OK) && (kind_q == ifre_pkg::KIND_STORE);
    fetch_ok = (code == ifre_pkg::ST_OK) && (kind_q == ifre_pkg::KIND_FETCH);

    unique case (m_q)
      ifre_pkg::MODE_HFLIP: begin
        ir = {1'b0, r_q};
        ic = frame_width - DW'(1) - {1'b0, c_q};
      end
      ifre_pkg::MODE_TRANS: begin
        ir = {1'b0, c_q};
        ic = {1'b0, r_q};
      end
      ifre_pkg::MODE_CW: begin
        ir = frame_height - DW'(1) - {1'b0, c_q};
        ic = {1'b0, r_q};
      end
      ifre_pkg::MODE_CCW: begin
        ir = {1'b0, c_q};
        ic = frame_width - DW'(1) - {1'b0, r_q};
      end
      default: begin
        ir = frame_height - DW'(1) - {1'b0, r_q};
        ic = {1'b0, c_q};
      end
    endcase

    idx_full = (ir * frame_width) + TW'(ic);
    last     = ({1'b0, r_q} == oh_q - DW'(1)) && ({1'b0, c_q} == ow_q - DW'(1));
    c_inc    = {1'b0, c_q} + DW'(1);
  end

  assign ram_we = cmd.addr && store_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      read_row     <= '0;
      read_col     <= '0;
    end else if (cmd.addr) begin
      if (store_ok) begin
        stored_count <= stored_count + CW'(1);
      end else if (fetch_ok) begin
        if (last) begin
          stored_count <= '0;
          read_row     <= '0;
          read_col     <= '0;
        end else if (c_inc >= ow_q) begin
          read_col <= '0;
          read_row <= r_q + PW'(1);
        end else begin
          read_col <= c_inc[PW-1:0];
          read_row <= r_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      code_q <= code;
      last_q <= fetch_ok && last;
      idx_q  <= idx_full[AW-1:0];
    end
  end

  ifre_ram #(
    .WIDTH(ifre_pkg::W_PIX),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(stored_count[AW-1:0]),
    .wdata(pix_q),
    .re   (cmd.read),
    .raddr(idx_q),
    .rdata(ram_rdata)
  );

  // Output register
  assign good_fetch_q = (code_q == ifre_pkg::ST_OK) && (kind_q == ifre_pkg::KIND_FETCH);
  assign taken        = out_valid && !out_stall;
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (taken) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= code_q;
      pixel_out  <= good_fetch_q ? ram_rdata : '0;
      out_row    <= good_fetch_q ? r_q : '0;
      out_col    <= good_fetch_q ? c_q : '0;
      last_pixel <= last_q;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CW'(MAX_PIXELS))
    else $error("stored pixel count beyond store size");

  a_write_fits: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (TW'(stored_count) < total_q))
    else $error("store write past end of frame");

  a_last_is_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (out_valid && (!last_pixel || status == ifre_pkg::ST_OK)))
    else $error("last pixel mark on a faulted word");
`endif

endmodule

@@ hdl/image_flip_rotate_engine_top.sv @@
// Top level of the frame flip / transpose / rotate engine.
`timescale 1ns / 1ps
//
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------------------
// in      | sink      | in_valid / in_stall | kind, pixel_in
// out     | source    | out_valid/out_stall | status, pixel_out, out_row, out_col, last_pixel
// cfg     | sink      | cfg_we              | cfg_index, cfg_data (no read-back)
//
// Each word passes from acceptance to the next acceptance through eval (dims, wrap,
// w*h), address (status, row*width+col multiply, store write), frame store read
// (registered RAM), response. The store's registered read sets the read stage.
// A stalled output word holds the engine in its response step; the input side is
// stalled until the response is loaded into the output register.
// Synchronous active-high reset resets counters and control registers; the frame store is
// not cleared and needs no clearing pass, since every entry is written before read.
module image_flip_rotate_engine_top #(
  parameter int MAX_PIXELS = ifre_pkg::MAX_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [ifre_pkg::W_CFGI-1:0]   cfg_index,
  input  logic [ifre_pkg::W_DIM-1:0]    cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [ifre_pkg::W_PIX-1:0]    pixel_in,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ifre_pkg::W_STAT-1:0]   status,
  output logic [ifre_pkg::W_PIX-1:0]    pixel_out,
  output logic [ifre_pkg::W_POS-1:0]    out_row,
  output logic [ifre_pkg::W_POS-1:0]    out_col,
  output logic                          last_pixel
);

  ifre_pkg::ifre_cmd_t cmd;
  ifre_pkg::ifre_sts_t sts;

  // Sequencer: one word in flight
  ifre_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  // Datapath: config regs, counters, address math, frame store, output register
  ifre_dp #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .pixel_out (pixel_out),
    .out_row   (out_row),
    .out_col   (out_col),
    .last_pixel(last_pixel)
  );

endmodule

@@ tb/tb_image_flip_rotate_engine_top.sv @@
// Self-checking testbench for the frame flip / transpose / rotate engine.
`timescale 1ns / 1ps
module tb_image_flip_rotate_engine_top;

  // Settling wait after the owed results have drained, before touching registers.
  localparam int LAT_WAIT    = 8;
  // Long output hold-off: the engine backs up and stalls its input side.
  localparam int HOLD_CYCLES = 400;
  // Cycles without any handshake or register write before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  // Random words, split evenly over the four idle/stall profiles.
  localparam int RAND_WORDS  = 700;
  // Width shorthands for casts
  localparam int PIX_W = ifre_pkg::W_PIX;
  localparam int POS_W = ifre_pkg::W_POS;
  localparam int DIM_W = ifre_pkg::W_DIM;

  // One result word, field for field as the engine presents it.
  typedef struct packed {
    logic [ifre_pkg::W_STAT-1:0] status;
    logic [ifre_pkg::W_PIX-1:0]  pixel;
    logic [ifre_pkg::W_POS-1:0]  row;
    logic [ifre_pkg::W_POS-1:0]  col;
    logic                        last;
  } pix_result_t;

  // Directed plan row: either a register write or an input word.
  // Rows with typed set carry their own result; the rest use the predictor.
  typedef struct packed {
    logic                        is_reg;
    logic [ifre_pkg::W_CFGI-1:0] reg_idx;
    logic [ifre_pkg::W_DIM-1:0]  reg_val;
    logic                        kind;
    logic [ifre_pkg::W_PIX-1:0]  pix;
    logic                        typed;
    pix_result_t                 want;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic [ifre_pkg::W_CFGI-1:0] cfg_index;
  logic [ifre_pkg::W_DIM-1:0]  cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic                        kind;
  logic [ifre_pkg::W_PIX-1:0]  pixel_in;
  logic                        out_valid;
  logic                        out_stall;
  logic [ifre_pkg::W_STAT-1:0] status;
  logic [ifre_pkg::W_PIX-1:0]  pixel_out;
  logic [ifre_pkg::W_POS-1:0]  out_row;
  logic [ifre_pkg::W_POS-1:0]  out_col;
  logic                        last_pixel;

  // Predictor copy of the engine: frame store, fill count, scan position, registers.
  logic [ifre_pkg::W_PIX-1:0]  frame_mem [ifre_pkg::MAX_PIXELS_DEF];
  int unsigned                 fill_cnt;
  int unsigned                 scan_row;
  int unsigned                 scan_col;
  logic [ifre_pkg::W_MODE-1:0] cfg_mode;
  logic [ifre_pkg::W_DIM-1:0]  cfg_w;
  logic [ifre_pkg::W_DIM-1:0]  cfg_h;

  // Results still owed by the engine, oldest first.
  pix_result_t due_results [$];
  plan_row_t   plan [$];

  int   errors      = 0;
  int   n_words     = 0;
  int   n_results   = 0;
  int   n_frames    = 0;
  int   idle_cycles = 0;
  int   tx_pct      = 0;   // chance in 100 that the sender idles a cycle
  int   rx_pct      = 0;   // chance in 100 that the receiver stalls a cycle
  int   hold_req    = 0;   // bumped by the stimulus to ask for one long hold-off

  image_flip_rotate_engine_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .pixel_out  (pixel_out),
    .out_row    (out_row),
    .out_col    (out_col),
    .last_pixel (last_pixel)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Next result of the engine for one accepted word; updates the predictor state.
  task automatic reorient_word(input logic k, input logic [ifre_pkg::W_PIX-1:0] p,
                               output pix_result_t res);
    int unsigned w, h, tot, ow, oh, r, c, ir, ic;
    logic [ifre_pkg::W_MODE-1:0] m;
    res = '0;
    w = cfg_w;
    h = cfg_h;
    // codes above the last transform behave as a vertical flip
    m = (cfg_mode > ifre_pkg::MODE_CCW) ? ifre_pkg::MODE_VFLIP : cfg_mode;
    // bad geometry: every word is refused and nothing moves
    if (w == 0 || h == 0 || w > ifre_pkg::MAX_DIM || h > ifre_pkg::MAX_DIM ||
        w * h > ifre_pkg::MAX_PIXELS_DEF) begin
      res.status = ifre_pkg::ST_TOOBIG;
      return;
    end
    tot = w * h;
    if (k == ifre_pkg::KIND_STORE) begin
      if (fill_cnt >= tot) begin
        res.status = ifre_pkg::ST_FULL;
      end else begin
        frame_mem[fill_cnt] = p;
        fill_cnt++;
      end
      return;
    end
    if (fill_cnt < tot) begin
      res.status = ifre_pkg::ST_EARLY;
      return;
    end
    // transpose and both rotations swap the output dimensions
    if (m >= ifre_pkg::MODE_TRANS) begin
      ow = h;
      oh = w;
    end else begin
      ow = w;
      oh = h;
    end
    // geometry changed under a partly read frame: scan restarts at the origin
    if (scan_row >= oh || scan_col >= ow) begin
      scan_row = 0;
      scan_col = 0;
    end
    r = scan_row;
    c = scan_col;
    case (m)
      ifre_pkg::MODE_HFLIP: begin ir = r;         ic = w - 1 - c; end
      ifre_pkg::MODE_TRANS: begin ir = c;         ic = r;         end
      ifre_pkg::MODE_CW:    begin ir = h - 1 - c; ic = r;         end
      ifre_pkg::MODE_CCW:   begin ir = c;         ic = w - 1 - r; end
      default:              begin ir = h - 1 - r; ic = c;         end
    endcase
    res.pixel = frame_mem[ir * w + ic];
    res.row   = POS_W'(r);
    res.col   = POS_W'(c);
    res.last  = (r == oh - 1 && c == ow - 1);
    // last pixel out clears the frame for the next one
    if (res.last) begin
      fill_cnt = 0;
      scan_row = 0;
      scan_col = 0;
      n_frames++;
    end else if (c + 1 >= ow) begin
      scan_col = 0;
      scan_row = r + 1;
    end else begin
      scan_col = c + 1;
    end
  endtask

  // Offer one word, wait for the handshake, then log what the engine owes for it.
  // Valid stays high on return so back-to-back words need no drop in between.
  task automatic send_word(input logic k, input logic [ifre_pkg::W_PIX-1:0] p,
                           input logic use_typed, input pix_result_t typed_res,
                           output pix_result_t res);
    int gap;
    gap = 0;
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    pixel_in <= p;
    do @(posedge clk); while (in_stall);
    reorient_word(k, p, res);
    due_results.push_back(use_typed ? typed_res : res);
    n_words++;
  endtask

  // Stop sending and let every owed result come back, then let the engine settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  // Register writes only land on an idle engine.
  task automatic write_reg(input logic [ifre_pkg::W_CFGI-1:0] idx,
                           input logic [ifre_pkg::W_DIM-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ifre_pkg::REG_MODE:   cfg_mode = val[ifre_pkg::W_MODE-1:0];
      ifre_pkg::REG_WIDTH:  cfg_w    = val;
      ifre_pkg::REG_HEIGHT: cfg_h    = val;
      default: ;
    endcase
  endtask

  // Program a geometry and push one frame through: fill, then read out to the last pixel.
  // Noisy frames mix in wrong-kind words and are sometimes abandoned part way,
  // which leaves a partial fill or scan position for the next geometry.
  task automatic run_frame(input logic [ifre_pkg::W_DIM-1:0] mode_val, input int unsigned w,
                           input int unsigned h, input bit noisy);
    pix_result_t res;
    logic        k;
    int unsigned cut, n;
    bit          done;
    write_reg(ifre_pkg::REG_MODE, mode_val);
    write_reg(ifre_pkg::REG_WIDTH, DIM_W'(w));
    write_reg(ifre_pkg::REG_HEIGHT, DIM_W'(h));
    if (w == 0 || h == 0 || w > ifre_pkg::MAX_DIM || h > ifre_pkg::MAX_DIM ||
        w * h > ifre_pkg::MAX_PIXELS_DEF) begin
      repeat ($urandom_range(1, 3)) send_word(1'($urandom_range(1)), $urandom, 1'b0, '0, res);
      return;
    end
    cut  = (noisy && $urandom_range(99) < 12) ? $urandom_range(1, 2 * w * h) : 0;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      k = (fill_cnt < w * h) ? ifre_pkg::KIND_STORE : ifre_pkg::KIND_FETCH;
      // wrong kind: store into a full frame or fetch from an incomplete one
      if (noisy && $urandom_range(99) < 4) k = ~k;
      send_word(k, $urandom, 1'b0, '0, res);
      n++;
      done = (k == ifre_pkg::KIND_FETCH && res.last) || (cut != 0 && n >= cut);
    end
  endtask

  function automatic plan_row_t reg_row(logic [ifre_pkg::W_CFGI-1:0] idx,
                                        logic [ifre_pkg::W_DIM-1:0] val);
    plan_row_t pr;
    pr         = '0;
    pr.is_reg  = 1'b1;
    pr.reg_idx = idx;
    pr.reg_val = val;
    return pr;
  endfunction

  function automatic plan_row_t word_row(logic k, logic [ifre_pkg::W_PIX-1:0] p);
    plan_row_t pr;
    pr      = '0;
    pr.kind = k;
    pr.pix  = p;
    return pr;
  endfunction

  function automatic plan_row_t typed_row(logic k, logic [ifre_pkg::W_PIX-1:0] p,
                                          logic [ifre_pkg::W_STAT-1:0] st,
                                          logic [ifre_pkg::W_PIX-1:0] px, logic lst);
    plan_row_t pr;
    pr             = word_row(k, p);
    pr.typed       = 1'b1;
    pr.want.status = st;
    pr.want.pixel  = px;
    pr.want.last   = lst;
    return pr;
  endfunction

  task automatic match_field(input string name, input logic [ifre_pkg::W_PIX-1:0] want,
                             input logic [ifre_pkg::W_PIX-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker and progress counter. Samples at the edge, before any update.
  always @(posedge clk) begin
    pix_result_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        n_results++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected word: expected none, got status %0h pixel %0h",
                   $time, status, pixel_out);
          errors++;
        end else begin
          want = due_results.pop_front();
          match_field("status", PIX_W'(want.status), PIX_W'(status));
          match_field("pixel_out", want.pixel, pixel_out);
          match_field("out_row", PIX_W'(want.row), PIX_W'(out_row));
          match_field("out_col", PIX_W'(want.col), PIX_W'(out_col));
          match_field("last_pixel", PIX_W'(want.last), PIX_W'(last_pixel));
        end
      end
    end
  end

  // Receiver: random stalls per profile, or one long hold-off when asked.
  initial begin
    int hold_seen;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
      end
    end
  end

  // Hang detector.
  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    pix_result_t res;
    int unsigned w, h, m, sel;
    int          base;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = ifre_pkg::KIND_STORE;
    pixel_in  = '0;
    fill_cnt  = 0;
    scan_row  = 0;
    scan_col  = 0;
    cfg_mode  = ifre_pkg::MODE_VFLIP;
    cfg_w     = 1;
    cfg_h     = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---------------- directed part ----------------
    // Reset geometry is 1x1: fetch too early, fill, overfill, read the lone pixel.
    plan.push_back(typed_row(ifre_pkg::KIND_FETCH, 32'h0000_0000, ifre_pkg::ST_EARLY,
                             32'h0, 1'b0));
    plan.push_back(typed_row(ifre_pkg::KIND_STORE, 32'hFFFF_FFFF, ifre_pkg::ST_OK,
                             32'h0, 1'b0));
    plan.push_back(typed_row(ifre_pkg::KIND_STORE, 32'h0000_0000, ifre_pkg::ST_FULL,
                             32'h0, 1'b0));
    plan.push_back(typed_row(ifre_pkg::KIND_FETCH, 32'hFFFF_FFFF, ifre_pkg::ST_OK,
                             32'hFFFF_FFFF, 1'b1));
    // readout of the last pixel emptied the frame
    plan.push_back(typed_row(ifre_pkg::KIND_FETCH, 32'h0000_0000, ifre_pkg::ST_EARLY,
                             32'h0, 1'b0));
    // bad geometry: zero width, all-ones width, too many pixels, zero height
    plan.push_back(reg_row(ifre_pkg::REG_WIDTH, 11'd0));
    plan.push_back(typed_row(ifre_pkg::KIND_STORE, 32'hA5A5_A5A5, ifre_pkg::ST_TOOBIG,
                             32'h0, 1'b0));
    plan.push_back(reg_row(ifre_pkg::REG_WIDTH, 11'h7FF));
    plan.push_back(typed_row(ifre_pkg::KIND_FETCH, 32'h5A5A_5A5A, ifre_pkg::ST_TOOBIG,
                             32'h0, 1'b0));
    plan.push_back(reg_row(ifre_pkg::REG_WIDTH, 11'd1024));
    plan.push_back(reg_row(ifre_pkg::REG_HEIGHT, 11'd17));
    plan.push_back(typed_row(ifre_pkg::KIND_STORE, 32'h0000_0001, ifre_pkg::ST_TOOBIG,
                             32'h0, 1'b0));
    plan.push_back(reg_row(ifre_pkg::REG_HEIGHT, 11'd0));
    plan.push_back(typed_row(ifre_pkg::KIND_STORE, 32'h8000_0000, ifre_pkg::ST_TOOBIG,
                             32'h0, 1'b0));
    // 1024 x 16 fills the store exactly and is legal
    plan.push_back(reg_row(ifre_pkg::REG_HEIGHT, 11'd16));
    plan.push_back(typed_row(ifre_pkg::KIND_FETCH, 32'h0000_0000, ifre_pkg::ST_EARLY,
                             32'h0, 1'b0));
    plan.push_back(typed_row(ifre_pkg::KIND_STORE, 32'h5A5A_5A5A, ifre_pkg::ST_OK,
                             32'h0, 1'b0));
    // shrink to 2x2 clockwise: the pixel already stored counts toward the new frame
    plan.push_back(reg_row(ifre_pkg::REG_MODE, DIM_W'(ifre_pkg::MODE_CW)));
    plan.push_back(reg_row(ifre_pkg::REG_WIDTH, 11'd2));
    plan.push_back(reg_row(ifre_pkg::REG_HEIGHT, 11'd2));
    plan.push_back(word_row(ifre_pkg::KIND_STORE, 32'h0000_0001));
    plan.push_back(word_row(ifre_pkg::KIND_STORE, 32'h8000_0000));
    plan.push_back(word_row(ifre_pkg::KIND_STORE, 32'h1234_5678));
    plan.push_back(word_row(ifre_pkg::KIND_FETCH, 32'h0));
    plan.push_back(word_row(ifre_pkg::KIND_FETCH, 32'h0));
    plan.push_back(word_row(ifre_pkg::KIND_FETCH, 32'h0));
    // mid-readout change to 1 wide, undefined mode code: scan column falls outside
    // the new output and restarts at the origin
    plan.push_back(reg_row(ifre_pkg::REG_MODE, 11'h7FF));
    plan.push_back(reg_row(ifre_pkg::REG_WIDTH, 11'd1));
    plan.push_back(reg_row(ifre_pkg::REG_HEIGHT, 11'd2));
    plan.push_back(word_row(ifre_pkg::KIND_FETCH, 32'hFFFF_FFFF));
    plan.push_back(word_row(ifre_pkg::KIND_FETCH, 32'h0));
    foreach (plan[i]) begin
      if (plan[i].is_reg)
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      else
        send_word(plan[i].kind, plan[i].pix, plan[i].typed, plan[i].want, res);
    end

    // One long frame: 256 wide, rotated so output rows run to 255.
    run_frame({8'h00, ifre_pkg::MODE_CCW}, 256, 1, 1'b0);

    // ---------------- random part ----------------
    base = n_words;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin tx_pct = 0;  rx_pct = 0;  end
        1:       begin tx_pct = 76; rx_pct = 0;  end
        2:       begin tx_pct = 0;  rx_pct = 76; end
        default: begin tx_pct = 9;  rx_pct = 9;  end
      endcase
      // Back-pressure: receiver holds off while words keep coming back to back.
      if (ph == 0) begin
        hold_req <= hold_req + 1;
        run_frame({8'h00, ifre_pkg::MODE_TRANS}, 4, 4, 1'b0);
      end
      while (n_words < base + (ph + 1) * RAND_WORDS / 4) begin
        sel = $urandom_range(99);
        if (sel < 6) begin
          case ($urandom_range(3))
            0:       begin w = 0; h = $urandom_range(0, 2047); end
            1:       begin
              w = $urandom_range(1, 64);
              h = $urandom_range(ifre_pkg::MAX_DIM + 1, 2047);
            end
            2:       begin
              w = $urandom_range(129, ifre_pkg::MAX_DIM);
              h = $urandom_range(129, ifre_pkg::MAX_DIM);
            end
            default: begin w = 2047; h = 2047; end
          endcase
        end else if (sel < 14) begin
          // long thin frames
          w = $urandom_range(1, 64);
          h = $urandom_range(1, 2);
          if ($urandom_range(1)) begin
            m = w;
            w = h;
            h = m;
          end
        end else begin
          w = $urandom_range(1, 6);
          h = $urandom_range(1, 6);
        end
        m = ($urandom_range(99) < 15) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        // upper data bits are don't-care for the mode register
        run_frame({8'($urandom), 3'(m)}, w, h, 1'b1);
      end
    end

    // drain, then give the engine its latency to show any stray word
    wait_idle();
    repeat (LAT_WAIT) @(posedge clk);

    $display("Run covered %0d words and %0d checked results over four idle/stall profiles,",
             n_words, n_results);
    $display("%0d complete frames in all transforms, bad geometry, early and full errors.",
             n_frames);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
